// File: rtl/udpcs_pkg.sv
// shared types and constants for the udp/ipv4 checksum stream block
// no dependencies; imported by every module of the block
package udpcs_pkg;

  localparam int WORD_W     = 16;
  localparam int RAW_W      = 20;  // ten 16-bit words summed without folding
  localparam int ACC_W      = 21;  // running sum plus one raw beat sum
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 16;

  // byte count codes
  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_ONE  = 2'd1;

  // one classified beat waiting for the accumulator
  typedef struct packed {
    logic             first;
    logic             last;
    logic [RAW_W-1:0] raw_sum;
  } beat_t;

  // queue status seen by the back end
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

endpackage

// File: rtl/udpcs_front.sv
// front end: unpacks an input item and sums its header and payload words
// depends on udpcs_pkg
module udpcs_front import udpcs_pkg::*; (
  input  logic                 first_beat,
  input  logic                 last_beat,
  input  logic [IN_DATA_W-1:0] tdata,
  output beat_t                beat
);

  logic [WORD_W-1:0] data_word;
  logic [1:0]        byte_count;
  logic [31:0]       source_address;
  logic [31:0]       dest_address;
  logic [7:0]        protocol_number;
  logic [WORD_W-1:0] udp_length;
  logic [WORD_W-1:0] source_port;
  logic [WORD_W-1:0] dest_port;
  logic [WORD_W-1:0] payload;
  logic [RAW_W-1:0]  hdr_sum;

  // field unpacking
  assign data_word       = tdata[15:0];
  assign byte_count      = tdata[17:16];
  assign source_address  = tdata[49:18];
  assign dest_address    = tdata[81:50];
  assign protocol_number = tdata[89:82];
  assign udp_length      = tdata[105:90];
  assign source_port     = tdata[121:106];
  assign dest_port       = tdata[137:122];

  // payload word after padding of an odd byte
  always_comb begin
    case (byte_count)
      BC_NONE: payload = '0;
      BC_ONE:  payload = {data_word[15:8], 8'h00};
      default: payload = data_word;
    endcase
  end

  // pseudo-header plus udp header, checksum field taken as zero
  assign hdr_sum = RAW_W'(source_address[31:16]) + RAW_W'(source_address[15:0])
                 + RAW_W'(dest_address[31:16])   + RAW_W'(dest_address[15:0])
                 + RAW_W'(protocol_number)       + RAW_W'(udp_length)
                 + RAW_W'(source_port)           + RAW_W'(dest_port)
                 + RAW_W'(udp_length);

  always_comb begin
    beat.first   = first_beat;
    beat.last    = last_beat;
    beat.raw_sum = (first_beat ? hdr_sum : '0) + RAW_W'(payload);
  end

endmodule

// File: rtl/udpcs_fifo.sv
// short register queue between the front end and the accumulator
// depends on udpcs_pkg
module udpcs_fifo import udpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  beat_t      wr_beat,
  input  logic       pop,
  output beat_t      head,
  output fifo_stat_t stat
);

  beat_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_beat;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// File: rtl/udpcs_back.sv
// back end: ones-complement accumulator with end-around carry and result register
// depends on udpcs_pkg
module udpcs_back import udpcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  beat_t                 head,
  input  fifo_stat_t            stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [WORD_W-1:0]     running_r, running_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [WORD_W-1:0]     base;
  logic [ACC_W-1:0]      total;
  logic [WORD_W:0]       fold1;
  logic [WORD_W-1:0]     acc;

  // a last item needs the result slot free or draining
  assign pop = !stat.empty && (!head.last || !out_valid_r || out_tready);

  // restart on a first item, then two end-around folds
  assign base  = head.first ? '0 : running_r;
  assign total = ACC_W'(base) + ACC_W'(head.raw_sum);
  assign fold1 = (WORD_W+1)'(total[WORD_W-1:0]) + (WORD_W+1)'(total[ACC_W-1:WORD_W]);
  assign acc   = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);

  always_comb begin
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      running_nxt = head.last ? '0 : acc;
      if (head.last) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ~acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/udp_ipv4_checksum_stream.sv
// top level of the udp/ipv4 checksum stream block
// depends on udpcs_pkg, udpcs_front, udpcs_fifo, udpcs_back

// Computes the UDP-over-IPv4 Internet checksum of a datagram streamed as
// 16-bit payload beats, first payload byte in the upper half. The beat with
// in_tuser high also carries the pseudo-header and UDP header fields; the beat
// with in_tlast high closes the datagram and yields one 16-bit checksum item
// on the output, the ones complement of the folded sum (zero is sent as zero).
// One item is taken every cycle while the queue has room: the front end sums
// a beat's words in the cycle it is accepted and writes them to a four-entry
// queue, and the accumulator retires one queued beat per cycle unless a last
// beat waits for the result register to drain. The checksum is registered
// there; the queue absorbs output stalls, and in_tready drops only when it is full.
module udp_ipv4_checksum_stream import udpcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] data_word, [17:16] byte_count, [49:18] source_address,
  // [81:50] dest_address, [89:82] protocol_number, [105:90] udp_length,
  // [121:106] source_port, [137:122] dest_port, [143:138] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] first_beat
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] checksum_value
  output logic [OUT_DATA_W-1:0] out_tdata
);

  beat_t      new_beat;
  beat_t      head;
  fifo_stat_t stat;
  logic       push;
  logic       pop;

  assign in_tready = !stat.full;
  assign push      = in_tvalid && in_tready;

  // classify and pre-sum each item
  udpcs_front u_front (
    .first_beat (in_tuser),
    .last_beat  (in_tlast),
    .tdata      (in_tdata),
    .beat       (new_beat)
  );

  // decoupling queue
  udpcs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_beat (new_beat),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  // accumulate and emit
  udpcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count above depth");

  // back pressure only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> stat.count == FIFO_CW'(FIFO_DEPTH))
    else $error("in_tready low with room in queue");

  // a new result comes only from a retired last item
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pop && head.last))
    else $error("result without a last item");

  // nothing popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

// File: verif/tb_udp_ipv4_checksum_stream.sv
`timescale 1ns / 100ps
// testbench for udp_ipv4_checksum_stream: directed beats, then random datagrams
// each checksum item is checked against an in-bench predictor; needs udpcs_pkg and the rtl
module tb_udp_ipv4_checksum_stream;
  import udpcs_pkg::*;

  localparam logic [1:0] BC_TWO   = 2'd2;
  localparam logic [1:0] BC_THREE = 2'd3;
  localparam int RANDOM_BEATS = 850;
  localparam int HOLD_CYCLES  = 90;
  localparam int FLOOD_BEATS  = 16;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT_NS = 5_000_000;

  // one payload beat with its header fields
  typedef struct {
    logic        first;
    logic        last;
    logic [15:0] data;
    logic [1:0]  bc;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [7:0]  proto;
    logic [15:0] ulen;
    logic [15:0] sport;
    logic [15:0] dport;
  } dgram_beat_t;

  // directed row: beat plus an optional hand-written checksum
  typedef struct {
    dgram_beat_t beat;
    bit          typed;
    logic [15:0] csum;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [15:0]   acc_sum = 16'h0000;
  logic [15:0]   pending_csums[$];
  directed_row_t directed_rows[$];
  int            beats_sent = 0;
  int            fail_count = 0;
  bit            tx_steady = 1'b0;
  bit            hold_req = 1'b0;

  udp_ipv4_checksum_stream i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ones-complement add with end-around carry
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // advance the running sum by one beat, report the checksum on a last beat
  task automatic fold_beat(input dgram_beat_t b, output bit emits, output logic [15:0] csum);
    logic [15:0] acc;
    acc = acc_sum;
    if (b.first) begin
      acc = 16'h0000;
      acc = ones_add(acc, b.saddr[31:16]);
      acc = ones_add(acc, b.saddr[15:0]);
      acc = ones_add(acc, b.daddr[31:16]);
      acc = ones_add(acc, b.daddr[15:0]);
      acc = ones_add(acc, {8'h00, b.proto});
      acc = ones_add(acc, b.ulen);
      acc = ones_add(acc, b.sport);
      acc = ones_add(acc, b.dport);
      acc = ones_add(acc, b.ulen);
    end
    case (b.bc)
      BC_NONE: ;
      BC_ONE: acc = ones_add(acc, {b.data[15:8], 8'h00});
      default: acc = ones_add(acc, b.data);
    endcase
    emits = b.last;
    csum = ~acc;
    acc_sum = b.last ? 16'h0000 : acc;
  endtask

  function automatic dgram_beat_t mk_beat(logic first, logic last, logic [15:0] data,
                                          logic [1:0] bc, logic [31:0] saddr,
                                          logic [31:0] daddr, logic [7:0] proto,
                                          logic [15:0] ulen, logic [15:0] sport,
                                          logic [15:0] dport);
    dgram_beat_t b;
    b.first = first;
    b.last = last;
    b.data = data;
    b.bc = bc;
    b.saddr = saddr;
    b.daddr = daddr;
    b.proto = proto;
    b.ulen = ulen;
    b.sport = sport;
    b.dport = dport;
    return b;
  endfunction

  function automatic dgram_beat_t rand_beat(logic first, logic last, logic [1:0] bc);
    return mk_beat(first, last, 16'($urandom), bc, $urandom, $urandom, 8'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic add_row(dgram_beat_t b, bit typed, logic [15:0] csum);
    directed_row_t row;
    row.beat = b;
    row.typed = typed;
    row.csum = csum;
    directed_rows.push_back(row);
  endtask

  // offer one item at the falling edge, hold it until taken
  task automatic send_beat(dgram_beat_t b, bit typed, logic [15:0] want);
    int          gap;
    bit          emits;
    logic [15:0] csum;
    gap = pick_gap(tx_steady);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.first;
    in_tlast <= b.last;
    in_tdata <= {6'd0, b.dport, b.sport, b.ulen, b.proto, b.daddr, b.saddr, b.bc, b.data};
    do @(posedge clk); while (!in_tready);
    fold_beat(b, emits, csum);
    if (emits) pending_csums.push_back(typed ? want : csum);
    beats_sent++;
  endtask

  // datagram with random content; first or last marker may be left out
  task automatic send_datagram(int len, bit with_first, bit with_last);
    logic [1:0] bc;
    bit         is_last;
    for (int i = 0; i < len; i++) begin
      is_last = with_last && (i == len - 1);
      if (is_last)
        bc = ($urandom_range(5) == 0) ? BC_NONE : 2'($urandom_range(2, 1));
      else
        bc = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : BC_TWO;
      send_beat(rand_beat(with_first && (i == 0), is_last, bc), 1'b0, 16'h0000);
    end
  endtask

  // back-to-back short datagrams while the receiver is held off
  task automatic flood_while_held();
    bit saved;
    saved = tx_steady;
    tx_steady = 1'b1;
    hold_req = 1'b1;
    repeat (FLOOD_BEATS) send_beat(rand_beat(1'b1, 1'b1, 2'($urandom_range(3))), 1'b0, 16'h0);
    tx_steady = saved;
  endtask

  // receiver: random stalls, steady stretches, and a long hold on each request
  initial begin
    int  gap;
    bit  rx_steady;
    rx_steady = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(149) == 0) rx_steady = !rx_steady;
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap(rx_steady);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // compare each checksum item with the oldest prediction
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_csums.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected checksum item %h", out_tdata);
      end else begin
        want = pending_csums.pop_front();
        if (out_tdata !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("checksum_value: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  // main sequence
  initial begin
    int len;
    int r;
    int stop_at;
    bit second_flood;
    second_flood = 1'b0;

    // after reset, no first beat: header ignored, empty sum
    add_row(mk_beat(0, 0, 16'hffff, BC_NONE, '1, '1, '1, '1, '1, '1), 1'b0, 16'h0);
    add_row(mk_beat(0, 1, 16'h0000, BC_NONE, '1, '1, '1, '1, '1, '1), 1'b1, 16'hffff);
    add_row(mk_beat(0, 1, 16'h0000, BC_NONE, '1, '1, '1, '1, '1, '1), 1'b1, 16'hffff);
    add_row(mk_beat(1, 1, 16'h0000, BC_NONE, '0, '0, '0, '0, '0, '0), 1'b1, 16'hffff);
    // sum of all ones gives a zero checksum, sent as zero
    add_row(mk_beat(1, 1, 16'hffff, BC_TWO, '0, '0, '0, '0, '0, '0), 1'b1, 16'h0000);
    // odd byte padded, byte count three as two
    add_row(mk_beat(1, 1, 16'h12ab, BC_ONE, '0, '0, '0, '0, '0, '0), 1'b1, 16'hedff);
    add_row(mk_beat(1, 1, 16'h1234, BC_THREE, '0, '0, '0, '0, '0, '0), 1'b1, 16'hedcb);
    // all fields at their maximum, then header fields one or two at a time
    add_row(mk_beat(1, 1, 16'hffff, BC_TWO, '1, '1, '1, '1, '1, '1), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h0000, BC_NONE, '1, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h0000, BC_NONE, '0, '1, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h0001, BC_TWO, '0, '0, '1, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h8000, BC_TWO, '0, '0, '0, '1, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h00ff, BC_ONE, '0, '0, '0, '0, '1, '1), 1'b0, 16'h0);
    // typical datagram: odd byte mid-stream, empty beat with header junk
    add_row(mk_beat(1, 0, 16'h4865, BC_TWO, 32'hc0a80001, 32'hc0a800c7, 8'h11,
                    16'h000d, 16'h1234, 16'h0035), 1'b0, 16'h0);
    add_row(mk_beat(0, 0, 16'h6c6c, BC_ONE, '0, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(0, 0, 16'h5555, BC_NONE, '1, '1, '1, '1, '1, '1), 1'b0, 16'h0);
    add_row(mk_beat(0, 1, 16'h6f21, BC_TWO, 32'h01020304, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    // no first beat after a last beat: sum restarts from zero
    add_row(mk_beat(0, 0, 16'h0102, BC_TWO, '0, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(0, 1, 16'h0304, BC_TWO, '0, '0, '0, '0, '0, '0), 1'b1, 16'hfbf9);
    // a second first beat discards the partial sum
    add_row(mk_beat(1, 0, 16'hbeef, BC_TWO, '1, '1, '1, '1, '1, '1), 1'b0, 16'h0);
    add_row(mk_beat(1, 1, 16'h0000, BC_NONE, '0, '0, '0, '0, '0, '0), 1'b1, 16'hffff);
    // payload extremes across beats
    add_row(mk_beat(1, 0, 16'h0000, BC_TWO, '0, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(0, 0, 16'hffff, BC_TWO, '0, '0, '0, '0, '0, '0), 1'b0, 16'h0);
    add_row(mk_beat(0, 1, 16'h8001, BC_ONE, '0, '0, '0, '0, '0, '0), 1'b0, 16'h0);

    // reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].csum);
    flood_while_held();

    // random part: mostly whole datagrams, some broken ones and noise
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) == 0) tx_steady = !tx_steady;
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      r = $urandom_range(99);
      if (r < 80)
        send_datagram(len, 1'b1, 1'b1);
      else if (r < 87)
        send_datagram(len, 1'b0, 1'b1);
      else if (r < 93)
        send_datagram(len, 1'b1, 1'b0);
      else
        repeat ($urandom_range(5, 1))
          send_beat(rand_beat(1'($urandom), 1'($urandom), 2'($urandom)), 1'b0, 16'h0);
      if (!second_flood && beats_sent > stop_at - RANDOM_BEATS / 2) begin
        second_flood = 1'b1;
        flood_while_held();
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain
    while (pending_csums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("udp_ipv4_checksum_stream: match");
    else
      $display("udp_ipv4_checksum_stream: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("udp_ipv4_checksum_stream: mismatch");
    $finish;
  end

endmodule
